### sv/hva_pkg.sv
// Shared types, constants and the arctangent table for the heading-angle pipeline.
`timescale 1ns / 1ps

package hva_pkg;

  // Default values of the top-level parameters.
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // Tabulated micro-rotations.
  localparam int TABLE_LEN = 24;

  // Coordinates are pre-scaled to a fixed 60-bit magnitude; gain and the
  // sign need three more bits.
  localparam int PRESCALE_TOP = 60;
  localparam int XY_WIDTH     = 63;

  // Angle accumulator: a full turn is 2^32.
  localparam int ANGLE_W = 32;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

  // Degrees in a full turn.
  localparam int DEG_TURN   = 360;
  localparam int DEG_TURN_W = 9;

  localparam int HEADING_W = 16;

  typedef struct packed {
    logic                       zero;
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic [ANGLE_W-1:0]         z;
  } cordic_t;

  typedef struct packed {
    logic               zero;
    logic [ANGLE_W-1:0] z;
  } angle_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### sv/vector_heading_angle_top.sv
// Top level of the vector heading-angle pipeline (CORDIC vectoring).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | request   | in_valid/in_stall  | in_vec_x, in_vec_y (signed)
//   out_    | result    | out_valid/out_stall| out_heading (1/2^F degree)
//
// One request enters per cycle unless a stage is stalled; each request
// yields one heading after one input stage, one register per micro-rotation,
// then offset, multiply and round. The micro-rotation chain sets the
// latency; throughput is one per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties every stage; no clearing pass.
// A stage holds its item while the next one is full and stalled; empty
// stages keep accepting, so bubbles collapse and nothing is lost or repeated.
`timescale 1ns / 1ps

module vector_heading_angle_top import hva_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [HEADING_W-1:0]          out_heading
);

  // Stages beyond the tabulated arctangents are dropped.
  localparam int NumStages = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // Link k joins the prep stage (k = 0) or micro-rotation k-1 to the next part.
  logic    link_valid [NumStages+1];
  logic    link_ready [NumStages+1];
  cordic_t link_data  [NumStages+1];

  logic    in_ready;
  angle_t  post_in;

  // Stall upstream only when the input register is full and cannot advance.
  assign in_stall = !in_ready;

  hva_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_x     (in_vec_x),
    .up_y     (in_vec_y),
    .up_ready (in_ready),
    .dn_valid (link_valid[0]),
    .dn_data  (link_data[0]),
    .dn_ready (link_ready[0])
  );

  // One register stage per micro-rotation.
  for (genvar g = 0; g < NumStages; g++) begin : g_rot
    hva_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[g]),
      .up_data  (link_data[g]),
      .up_ready (link_ready[g]),
      .dn_valid (link_valid[g+1]),
      .dn_data  (link_data[g+1]),
      .dn_ready (link_ready[g+1])
    );
  end

  // Only the accumulated angle and the zero-vector flag go on.
  assign post_in.zero = link_data[NumStages].zero;
  assign post_in.z    = link_data[NumStages].z;

  hva_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (link_valid[NumStages]),
    .up_data    (post_in),
    .up_ready   (link_ready[NumStages]),
    .dn_valid   (out_valid),
    .dn_heading (out_heading),
    .dn_ready   (!out_stall)
  );

endmodule

### sv/hva_prep.sv
// Input stage: pre-scale, fold the left half-plane and flag the zero vector.
`timescale 1ns / 1ps

module hva_prep import hva_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  input  logic signed [COORD_WIDTH-1:0] up_x,
  input  logic signed [COORD_WIDTH-1:0] up_y,
  output logic                          up_ready,
  output logic                          dn_valid,
  output cordic_t                       dn_data,
  input  logic                          dn_ready
);

  localparam int Prescale = PRESCALE_TOP - COORD_WIDTH;

  logic                       valid_r;
  cordic_t                    data_r;
  cordic_t                    data_nxt;
  logic signed [XY_WIDTH-1:0] x_s;
  logic signed [XY_WIDTH-1:0] y_s;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    x_s = {{(XY_WIDTH-COORD_WIDTH){up_x[COORD_WIDTH-1]}}, up_x} <<< Prescale;
    y_s = {{(XY_WIDTH-COORD_WIDTH){up_y[COORD_WIDTH-1]}}, up_y} <<< Prescale;
    data_nxt.zero = (up_x == '0) && (up_y == '0);
    if (up_x[COORD_WIDTH-1]) begin
      // turn by half a turn into the right half-plane
      data_nxt.x = -x_s;
      data_nxt.y = -y_s;
      data_nxt.z = HALF_TURN;
    end else begin
      data_nxt.x = x_s;
      data_nxt.y = y_s;
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### sv/hva_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
`timescale 1ns / 1ps

module hva_cordic_stage import hva_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  input  cordic_t up_data,
  output logic    up_ready,
  output logic    dn_valid,
  output cordic_t dn_data,
  input  logic    dn_ready
);

  localparam logic [ANGLE_W-1:0] AtanStep = atan_turn(5'(IDX));

  logic                       valid_r;
  cordic_t                    data_r;
  cordic_t                    data_nxt;
  logic signed [XY_WIDTH-1:0] dx;
  logic signed [XY_WIDTH-1:0] dy;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    dx = up_data.y >>> IDX;
    dy = up_data.x >>> IDX;
    data_nxt.zero = up_data.zero;
    if (up_data.y > 0) begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + AtanStep;
    end else begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - AtanStep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### sv/hva_post.sv
// Output stages: quarter-turn offset, scale to degree units, round and wrap.
`timescale 1ns / 1ps

module hva_post import hva_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  angle_t               up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output logic [HEADING_W-1:0] dn_heading,
  input  logic                 dn_ready
);

  localparam int UnitW = DEG_TURN_W + ANGLE_FRAC_BITS;
  localparam int ProdW = ANGLE_W + UnitW;
  localparam logic [UnitW-1:0] Units     = UnitW'(DEG_TURN) << ANGLE_FRAC_BITS;
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(HALF_TURN);

  logic                           v1_r, v2_r, v3_r;
  logic                           rdy1, rdy2, rdy3;
  logic [ANGLE_W-1:0]             turn_r;
  logic [ANGLE_W-1:0]             turn_nxt;
  logic [ProdW-1:0]               prod_r;
  logic [ProdW-1:0]               prod_nxt;
  logic [ProdW-1:0]               rounded;
  logic [UnitW-1:0]               units_h;
  logic [UnitW+HEADING_W-1:0]     h_ext;
  logic [HEADING_W-1:0]           heading_r;
  logic [HEADING_W-1:0]           heading_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    turn_nxt    = (up_data.zero ? '0 : up_data.z) + QUARTER_TURN;
    prod_nxt    = ProdW'(turn_r) * ProdW'(Units);
    rounded     = prod_r + RoundHalf;
    units_h     = rounded[ProdW-1:ANGLE_W];
    // a full turn after rounding wraps to zero
    if (units_h >= Units) begin
      units_h = '0;
    end
    h_ext       = {{HEADING_W{1'b0}}, units_h};
    heading_nxt = h_ext[HEADING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) turn_r    <= turn_nxt;
    if (rdy2 && v1_r)     prod_r    <= prod_nxt;
    if (rdy3 && v2_r)     heading_r <= heading_nxt;
  end

  assign dn_valid   = v3_r;
  assign dn_heading = heading_r;

endmodule

### sv/hva_checker.sv
// Port-level checks on the heading-angle pipeline, bound to the top level.
`timescale 1ns / 1ps

module hva_checker import hva_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [COORD_WIDTH-1:0] in_vec_x,
  input logic signed [COORD_WIDTH-1:0] in_vec_y,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [HEADING_W-1:0]          out_heading
);

  localparam int FullTurn   = DEG_TURN << ANGLE_FRAC_BITS;
  localparam bit RangeCheck = FullTurn <= (1 << HEADING_W);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_heading))
    else $error("result changed while stalled");

  // Reset empties the whole pipeline, output included.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // The rounded angle wraps below one full turn.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && RangeCheck |-> 32'(out_heading) < FullTurn)
    else $error("heading at or beyond a full turn");

  // A stalled request stays offered and keeps its fields.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_vec_x) && $stable(in_vec_y))
    else $error("request changed while stalled");

endmodule

bind vector_heading_angle_top hva_checker #(
  .COORD_WIDTH     (COORD_WIDTH),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_hva_checker (.*);

### dv/tb_vector_heading_angle_top.sv
// Self-checking testbench for the vector heading-angle pipeline.
`timescale 1ns / 1ps

module tb_vector_heading_angle_top;
  import hva_pkg::*;

  localparam int XW        = 16;
  localparam int ROTATIONS = 16;                // min(CORDIC_STAGES, table length)
  localparam int FRAC      = 7;
  localparam int SHIFT_UP  = 60 - XW;           // coordinate pre-scale
  localparam longint unsigned TURN_UNITS = 64'd360 << FRAC;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam int DRAIN_CYCLES = 40;             // pipeline is 20 deep

  // atan(2^-i) as a fraction of a turn, full turn = 2^32; index 0 first.
  localparam logic [0:23][31:0] ATAN_TURNS = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [XW-1:0] in_vec_x;
  logic signed [XW-1:0] in_vec_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [HEADING_W-1:0] out_heading;

  // Headings owed by the block, oldest first.
  logic [HEADING_W-1:0] heading_q[$];
  int                   mismatch_count;

  // When set, the side runs back to back with no idle cycles.
  bit                   in_quiet;
  bit                   out_quiet;

  vector_heading_angle_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_heading(out_heading)
  );

  // 2 ns clock: 1 ns high, 1 ns low.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Heading predictor: CORDIC vectoring on a 32-bit turn accumulator, then
  // quarter-turn offset, scale to 1/128 degree, round half up, wrap.
  function automatic logic [HEADING_W-1:0] heading_of(input logic signed [XW-1:0] vx,
                                                      input logic signed [XW-1:0] vy);
    longint          px;
    longint          py;
    longint          ddx;
    longint          ddy;
    logic [31:0]     acc;
    logic [31:0]     turn;
    longint unsigned scaled;
    acc = '0;
    if (vx != 0 || vy != 0) begin
      px = longint'(vx) * (longint'(1) << SHIFT_UP);
      py = longint'(vy) * (longint'(1) << SHIFT_UP);
      // Fold the left half-plane over and remember the half turn.
      if (px < 0) begin
        px  = -px;
        py  = -py;
        acc = HALF;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
        ddx = py >>> i;
        ddy = px >>> i;
        if (py > 0) begin
          px  = px + ddx;
          py  = py - ddy;
          acc = acc + ATAN_TURNS[i];
        end else begin
          px  = px - ddx;
          py  = py + ddy;
          acc = acc - ATAN_TURNS[i];
        end
      end
    end
    turn   = acc + QUARTER;
    scaled = (longint'({32'b0, turn}) * TURN_UNITS + 64'h8000_0000) >> 32;
    // A rounded full turn reads as zero.
    if (scaled >= TURN_UNITS) scaled = 0;
    return scaled[HEADING_W-1:0];
  endfunction

  // Offer one request; hold it until the block takes it, then log the
  // expected heading. Valid stays high into the next request when no gap
  // is drawn, so it is never dropped and raised in the same step.
  task automatic send_vector(input logic signed [XW-1:0] vx, input logic signed [XW-1:0] vy);
    int gap;
    bit took;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    // Sample stall mid-cycle, where it is settled, and count the request
    // as taken at the following rising edge.
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    heading_q.push_back(heading_of(vx, vy));
  endtask

  // Draw a vector from one of several shapes: wide random, tiny, near an
  // axis, near a diagonal, corner values, and just either side of straight down.
  task automatic random_vector(output logic signed [XW-1:0] vx,
                               output logic signed [XW-1:0] vy);
    int          kind;
    int          a;
    int          b;
    logic [31:0] raw;
    int          corners[5];
    corners = '{-32768, -1, 0, 1, 32767};
    kind = $urandom_range(0, 9);
    raw  = $urandom();
    a    = int'($urandom_range(0, 16)) - 8;
    b    = int'($urandom_range(0, 16)) - 8;
    case (kind)
      0, 1, 2, 3: begin
        vx = raw[15:0];
        vy = raw[31:16];
      end
      4: begin
        vx = XW'(a);
        vy = XW'(b);
      end
      5: begin
        vx = raw[15:0];
        vy = XW'(a);
      end
      6: begin
        vx = XW'(a);
        vy = raw[31:16];
      end
      7: begin
        vx = raw[15:0];
        vy = raw[16] ? XW'(int'(vx) + a) : XW'(-int'(vx) + a);
      end
      8: begin
        vx = XW'(corners[$urandom_range(0, 4)]);
        vy = XW'(corners[$urandom_range(0, 4)]);
      end
      default: begin
        vx = XW'(a);
        vy = XW'(-32768 + int'($urandom_range(0, 2000)));
      end
    endcase
  endtask

  // Result side: draw a stall for each heading, then take it and compare
  // against the oldest expectation.
  initial begin : result_checker
    int                   gap;
    bit                   took;
    logic [HEADING_W-1:0] got;
    logic [HEADING_W-1:0] want;
    out_stall <= 1'b0;
    // Start drawing stalls from the first edge on.
    @(posedge clk);
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        got  = out_heading;
        @(posedge clk);
      end while (!took);
      if (heading_q.size() == 0) begin
        $error("heading: no request outstanding, actual %0d", got);
        mismatch_count++;
      end else begin
        want = heading_q.pop_front();
        if (got !== want) begin
          $error("heading: expected %0d, actual %0d", want, got);
          mismatch_count++;
        end
      end
    end
  end

  // Corners of the coordinate range, the +x, +y and -y axes, and unit diagonals.
  task automatic test_extremes();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    send_vector(16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd32767, 16'sd0);
    send_vector(16'sd0, 16'sd32767);
    send_vector(16'sd0, -16'sd32768);
    send_vector(16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd0, -16'sd1);
    send_vector(16'sd1, -16'sd1);
    send_vector(-16'sd1, -16'sd1);
    send_vector(-16'sd1, 16'sd1);
  endtask

  // Zero vector, negative x on the axis, and headings that round up to a
  // full turn and must wrap to zero.
  task automatic test_special_cases();
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    send_vector(16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0);
    send_vector(-16'sd5, 16'sd0);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(-16'sd1, -16'sd32768);
    send_vector(-16'sd1, -16'sd20000);
    send_vector(16'sd1, -16'sd32768);
    send_vector(16'sd0, 16'sd0);
  endtask

  // Back-to-back requests against a receiver that stalls at random, so
  // the pipeline fills and holds.
  task automatic test_backpressure(input int count);
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    in_quiet  = 1'b1;
    out_quiet = 1'b0;
    repeat (count) begin
      random_vector(vx, vy);
      send_vector(vx, vy);
    end
  endtask

  // Full-rate streaming with neither side idling.
  task automatic test_full_rate(input int count);
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    repeat (count) begin
      random_vector(vx, vy);
      send_vector(vx, vy);
    end
  endtask

  // Random vectors; every 64 requests reshuffle which side idles, so
  // gaps land at every depth of the pipeline.
  task automatic test_random_vectors(input int count);
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      random_vector(vx, vy);
      send_vector(vx, vy);
    end
  endtask

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : main_sequence
    // Drive every input to a known value before the first edge.
    mismatch_count = 0;
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_vec_x <= '0;
    in_vec_y <= '0;
    // Hold reset low, then release it.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_special_cases();
    test_backpressure(200);
    test_full_rate(200);
    test_random_vectors(1100);

    // Drop valid once the last request is in, drain, then keep watching
    // to catch any stray result.
    in_valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
